// ----- src/spd_pkg.sv -----
// Shared types and constants for the sensor packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

   localparam int unsigned MAX_DATA_BYTES_DEF = 60;
   localparam int unsigned STATIC_TAXELS_DEF  = 28;
   localparam int unsigned QUEUE_DEPTH        = 4;

   localparam logic [7:0] SYNC_BYTE  = 8'h9A;
   localparam logic [2:0] NO_RECORD  = 3'd7;

   localparam logic [2:0] KIND_STATIC  = 3'd0;
   localparam logic [2:0] KIND_DYNAMIC = 3'd1;
   localparam logic [2:0] KIND_ACCEL   = 3'd2;
   localparam logic [2:0] KIND_GYRO    = 3'd3;
   localparam logic [2:0] KIND_MAG     = 3'd4;

   localparam logic EVENT_VALUE = 1'b0;
   localparam logic EVENT_END   = 1'b1;

   typedef struct packed {
      logic        has_value;
      logic        has_end;
      logic [2:0]  sensor_kind;
      logic [1:0]  finger_id;
      logic [4:0]  value_index;
      logic [15:0] sample_value;
      logic        set_complete;
   } spd_entry_type;

endpackage

`default_nettype wire

// ----- src/spd_front.sv -----
// Front end: frame tracking and record parsing, one request per cycle while the queue has room.
`timescale 1ns / 1ps
`default_nettype none

module spd_front
   import spd_pkg::*;
#(
   parameter int unsigned MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
   parameter int unsigned STATIC_TAXELS  = STATIC_TAXELS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          take,
   input  wire logic [7:0]    rx_byte,
   output spd_entry_type      entry,
   output logic               entry_push
);

   localparam logic [8:0] MAX_D   = 9'(MAX_DATA_BYTES);
   localparam logic [4:0] TAXELS  = 5'(STATIC_TAXELS);

   logic [8:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [2:0] sensor_ff, sensor_in;
   logic [1:0] finger_ff, finger_in;
   logic [4:0] count_ff, count_in;
   logic [7:0] hold_ff, hold_in;
   logic       pending_ff, pending_in;
   logic       halted_ff, halted_in;
   logic       dyn_ff, dyn_in;

   logic [8:0] d;
   logic [8:0] eff;
   logic       do_header;
   logic [3:0] nib;
   logic [4:0] count_next;
   logic [4:0] need;

   always_comb begin
      pos_in     = pos_ff;
      len_in     = len_ff;
      sensor_in  = sensor_ff;
      finger_in  = finger_ff;
      count_in   = count_ff;
      hold_in    = hold_ff;
      pending_in = pending_ff;
      halted_in  = halted_ff;
      dyn_in     = dyn_ff;
      entry      = '0;
      do_header  = 1'b0;
      nib        = rx_byte[7:4];
      d          = pos_ff - 9'd4;
      eff        = ({1'b0, len_ff} < MAX_D) ? {1'b0, len_ff} : MAX_D;
      count_next = count_ff + 5'd1;
      unique case (sensor_ff)
         KIND_STATIC: need = TAXELS;
         KIND_ACCEL, KIND_GYRO, KIND_MAG: need = 5'd3;
         default: need = 5'd1;
      endcase

      if (pos_ff == 9'd0) begin
         if (rx_byte == SYNC_BYTE) begin
            sensor_in  = NO_RECORD;
            finger_in  = '0;
            count_in   = '0;
            hold_in    = '0;
            pending_in = 1'b0;
            halted_in  = 1'b0;
            dyn_in     = 1'b0;
            pos_in     = 9'd1;
         end
      end else begin
         if (pos_ff == 9'd3) begin
            len_in = rx_byte;
         end else if (pos_ff >= 9'd4) begin
            if (d < eff && !halted_ff) begin
               if (sensor_ff == NO_RECORD) begin
                  do_header = 1'b1;
               end else if (!pending_ff) begin
                  if (d + 9'd1 == eff) begin
                     do_header = 1'b1;
                  end else begin
                     hold_in    = rx_byte;
                     pending_in = 1'b1;
                  end
               end else begin
                  entry.has_value    = 1'b1;
                  entry.sensor_kind  = sensor_ff;
                  entry.finger_id    = finger_ff;
                  entry.value_index  = count_ff;
                  entry.sample_value = {hold_ff, rx_byte};
                  pending_in         = 1'b0;
                  count_in           = count_next;
                  if (count_next >= need) begin
                     sensor_in = NO_RECORD;
                  end
               end
            end
         end

         if (do_header) begin
            if (nib < 4'd1 || nib > 4'd6) begin
               halted_in = 1'b1;
               sensor_in = NO_RECORD;
            end else begin
               sensor_in  = nib[2:0] - 3'd1;
               finger_in  = rx_byte[3:2];
               count_in   = '0;
               pending_in = 1'b0;
               if (nib[2:0] - 3'd1 == KIND_DYNAMIC) begin
                  dyn_in = 1'b1;
               end
            end
         end

         pos_in = pos_ff + 9'd1;
         if (pos_ff >= 9'd3 && pos_in >= {1'b0, len_in} + 9'd4) begin
            entry.has_end      = 1'b1;
            entry.set_complete = dyn_in;
            pos_in     = '0;
            sensor_in  = NO_RECORD;
            finger_in  = '0;
            count_in   = '0;
            hold_in    = '0;
            pending_in = 1'b0;
            halted_in  = 1'b0;
            dyn_in     = 1'b0;
         end
      end
   end

   assign entry_push = take && (entry.has_value || entry.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         len_ff     <= '0;
         sensor_ff  <= NO_RECORD;
         finger_ff  <= '0;
         count_ff   <= '0;
         hold_ff    <= '0;
         pending_ff <= 1'b0;
         halted_ff  <= 1'b0;
         dyn_ff     <= 1'b0;
      end else if (take) begin
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         sensor_ff  <= sensor_in;
         finger_ff  <= finger_in;
         count_ff   <= count_in;
         hold_ff    <= hold_in;
         pending_ff <= pending_in;
         halted_ff  <= halted_in;
         dyn_ff     <= dyn_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/spd_queue.sv -----
// Short queue of parsed entries between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module spd_queue
   import spd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire spd_entry_type push_entry,
   input  wire logic          pop,
   output spd_entry_type      head,
   output logic               not_empty,
   output logic               not_full
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   spd_entry_type    slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign not_empty = (cnt_ff != '0);
   assign not_full  = (cnt_ff != FULL_CNT);
   assign head      = slots_ff[rd_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = do_push ? ((wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1)) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1)) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- src/spd_back.sv -----
// Back end: output register that sends each entry as one or two responses.
`timescale 1ns / 1ps
`default_nettype none

module spd_back
   import spd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire spd_entry_type head,
   input  wire logic          head_valid,
   output logic               head_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_event_kind,
   output logic [2:0]         rsp_sensor_kind,
   output logic [1:0]         rsp_finger_id,
   output logic [4:0]         rsp_value_index,
   output logic [15:0]        rsp_sample_value,
   output logic               rsp_set_complete,
   output logic               rsp_last
);

   spd_entry_type cur_ff;
   logic          val_ff, val_in;
   logic          end_ff, end_in;
   logic          sent;
   logic          finishing;

   assign rsp_valid = val_ff || end_ff;
   assign sent      = rsp_valid && rsp_ready;
   assign finishing = sent && (val_ff != end_ff);
   assign head_pop  = head_valid && (!rsp_valid || finishing);

   always_comb begin
      val_in = val_ff;
      end_in = end_ff;
      if (sent) begin
         if (val_ff) begin
            val_in = 1'b0;
         end else begin
            end_in = 1'b0;
         end
      end
      if (head_pop) begin
         val_in = head.has_value;
         end_in = head.has_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= 1'b0;
         end_ff <= 1'b0;
      end else begin
         val_ff <= val_in;
         end_ff <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         cur_ff <= head;
      end
   end

   always_comb begin
      if (val_ff) begin
         rsp_event_kind   = EVENT_VALUE;
         rsp_sensor_kind  = cur_ff.sensor_kind;
         rsp_finger_id    = cur_ff.finger_id;
         rsp_value_index  = cur_ff.value_index;
         rsp_sample_value = cur_ff.sample_value;
         rsp_set_complete = 1'b0;
         rsp_last         = !end_ff;
      end else begin
         rsp_event_kind   = EVENT_END;
         rsp_sensor_kind  = '0;
         rsp_finger_id    = '0;
         rsp_value_index  = '0;
         rsp_sample_value = '0;
         rsp_set_complete = cur_ff.set_complete;
         rsp_last         = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ----- src/sensor_packet_deframer.sv -----
// Sensor packet deframer: takes one byte per cycle while the queue has room, returns decoded values.
// Path: the front parses in the accept cycle and writes the queue, and the
// back register loads from the queue head once the output register is free.
// Throughput: one request per cycle while the 4-entry queue has room; a byte
// with two responses holds the output register until both are sent.
// Reset: synchronous, clears frame state, queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module sensor_packet_deframer
   import spd_pkg::*;
#(
   parameter int unsigned MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
   parameter int unsigned STATIC_TAXELS  = STATIC_TAXELS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_rx_byte,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_event_kind,
   output logic [2:0]         rsp_sensor_kind,
   output logic [1:0]         rsp_finger_id,
   output logic [4:0]         rsp_value_index,
   output logic [15:0]        rsp_sample_value,
   output logic               rsp_set_complete,
   output logic               rsp_last
);

   spd_entry_type entry;
   spd_entry_type head;
   logic          entry_push;
   logic          head_valid;
   logic          head_pop;
   logic          take;

   assign take = req_valid && req_ready;

   spd_front #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES),
      .STATIC_TAXELS (STATIC_TAXELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .entry     (entry),
      .entry_push(entry_push)
   );

   spd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (entry_push),
      .push_entry(entry),
      .pop       (head_pop),
      .head      (head),
      .not_empty (head_valid),
      .not_full  (req_ready)
   );

   spd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (head_valid),
      .head_pop        (head_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_sensor_kind (rsp_sensor_kind),
      .rsp_finger_id   (rsp_finger_id),
      .rsp_value_index (rsp_value_index),
      .rsp_sample_value(rsp_sample_value),
      .rsp_set_complete(rsp_set_complete),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
